/* hw/rtl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the shelf atlas packer.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int unsigned RowDepthDef = 32;
  localparam int unsigned DimW        = 13;
  localparam int unsigned PosW        = 12;
  localparam int unsigned IdW         = 21;
  localparam int unsigned PageW       = 8;
  localparam int unsigned TotalW      = 9;

  localparam logic [DimW-1:0] PageWidthRst  = 13'd512;
  localparam logic [DimW-1:0] PageHeightRst = 13'd512;

  localparam logic RegPageWidth  = 1'b0;
  localparam logic RegPageHeight = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_PLACE,
    ST_LAST
  } sap_state_e;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [IdW-1:0]  id;
  } sap_entry_t;

  typedef struct packed {
    logic shift;
    logic wr_en;
  } sap_chain_ctrl_t;

endpackage

/* hw/rtl/sap_cell.sv */
// ----------------------------------------------------------------------------
// sap_cell
// One slot of the open row: loads a placed glyph or takes its upper neighbor.
// ----------------------------------------------------------------------------
module sap_cell
  import sap_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  sap_entry_t load_data_i,
  input  sap_entry_t next_i,
  output sap_entry_t data_o
);

  sap_entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

/* hw/rtl/sap_row_chain.sv */
// ----------------------------------------------------------------------------
// sap_row_chain
// Row store as a chain of cells that drains toward cell zero.
// ----------------------------------------------------------------------------
module sap_row_chain
  import sap_pkg::*;
#(
  parameter int unsigned Depth = RowDepthDef,
  parameter int unsigned FillW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  sap_chain_ctrl_t ctrl_i,
  input  logic [FillW-1:0] wr_pos_i,
  input  sap_entry_t      wr_entry_i,
  output sap_entry_t      head_o
);

  sap_entry_t cell_data [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    sap_entry_t next_data;
    logic       load;

    if (k == Depth - 1) begin : g_tail
      assign next_data = cell_data[k];
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end

    assign load = ctrl_i.wr_en && (wr_pos_i == FillW'(k));

    sap_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (ctrl_i.shift),
      .load_data_i (wr_entry_i),
      .next_i      (next_data),
      .data_o      (cell_data[k])
    );
  end

  assign head_o = cell_data[0];

endmodule

/* hw/rtl/shelf_atlas_packer.sv */
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// Shelf packing of glyph boxes into rows on fixed-size atlas pages.
// ----------------------------------------------------------------------------
// Sequence: a glyph is accepted in IDLE, checked in EVAL and written into the
// row cell chain in PLACE; a row break, or the last glyph via LAST, drains the row.
// The drain shifts placements out of the head of the row cell chain while the
// output is free. A new glyph is accepted only in IDLE, once the last is handled.
// Reset clears the layout state, the row fill and the output valid; the page
// registers return to 512 by 512.
// ----------------------------------------------------------------------------
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int unsigned ROW_DEPTH = RowDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DimW-1:0]  cfg_data_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // glyph_id, glyph_width, glyph_height, zero fill
  input  logic [47:0]      s_axis_tdata_i,
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // placed_id, pos_x, pos_y, page_index, page_total, zero fill
  output logic [63:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  // set_end
  output logic             m_axis_tuser_o
);

  localparam int unsigned FillW = $clog2(ROW_DEPTH + 1);

  sap_state_e       state_q, state_d;
  logic [DimW-1:0]  page_width_q, page_height_q;
  logic [DimW-1:0]  pen_x_q, pen_x_d;
  logic [DimW-1:0]  row_top_q, row_top_d;
  logic [DimW-1:0]  tallest_q, tallest_d;
  logic [PageW-1:0] page_q, page_d;
  logic [PageW-1:0] emit_page_q, emit_page_d;
  logic [PosW-1:0]  emit_y_q, emit_y_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             final_q, final_d;
  logic [IdW-1:0]   g_id_q;
  logic [DimW-1:0]  g_w_q, g_h_q;
  logic             g_last_q;

  logic             m_valid_q, m_valid_d;
  logic [63:0]      m_data_q, m_data_d;
  logic             m_last_q, m_last_d;
  logic             m_user_q, m_user_d;

  logic [DimW:0]    sum_x;
  logic [DimW+1:0]  need2;
  logic [DimW:0]    need1;
  logic             brk, move, out_free, in_acc, last_entry;
  logic [DimW-1:0]  top_new;
  logic [DimW:0]    top_sum;
  logic [DimW-1:0]  top_after;
  logic [PageW-1:0] page_inc;
  logic [PosW-1:0]  top_new_sat;
  logic [TotalW-1:0] total;

  sap_chain_ctrl_t  chain_ctrl;
  sap_entry_t       wr_entry, head;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign sum_x  = {1'b0, pen_x_q} + {1'b0, g_w_q};
  assign brk    = (sum_x > {1'b0, page_width_q}) || (fill_q >= FillW'(ROW_DEPTH));
  assign need2  = {2'b00, row_top_q} + {1'b0, tallest_q, 1'b0};
  assign need1  = {1'b0, row_top_q} + {1'b0, tallest_q};
  assign move   = (fill_q != '0) &&
                  ((state_q == ST_LAST) ? (need1 >= {1'b0, page_height_q})
                                        : (need2 >= {2'b00, page_height_q}));
  assign top_new     = move ? '0 : row_top_q;
  assign top_sum     = {1'b0, top_new} + {1'b0, tallest_q};
  assign top_after   = top_sum[DimW] ? '1 : top_sum[DimW-1:0];
  assign top_new_sat = top_new[DimW-1] ? '1 : top_new[PosW-1:0];
  assign page_inc    = (page_q == '1) ? page_q : page_q + 8'd1;
  assign last_entry  = (fill_q == FillW'(1));
  assign total       = {1'b0, emit_page_q} + 9'd1;

  assign wr_entry.id = g_id_q;
  assign wr_entry.x  = pen_x_q[DimW-1] ? '1 : pen_x_q[PosW-1:0];

  always_comb begin
    state_d     = state_q;
    pen_x_d     = pen_x_q;
    row_top_d   = row_top_q;
    tallest_d   = tallest_q;
    page_d      = page_q;
    emit_page_d = emit_page_q;
    emit_y_d    = emit_y_q;
    fill_d      = fill_q;
    final_d     = final_q;
    chain_ctrl  = '0;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;
    m_user_d    = m_user_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (brk) begin
          page_d      = move ? page_inc : page_q;
          emit_page_d = move ? page_inc : page_q;
          emit_y_d    = top_new_sat;
          row_top_d   = top_after;
          pen_x_d     = '0;
          tallest_d   = '0;
          final_d     = 1'b0;
          state_d     = ST_DRAIN;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_DRAIN: begin
        if (fill_q == '0) begin
          state_d = final_q ? ST_IDLE : ST_PLACE;
        end else if (out_free) begin
          chain_ctrl.shift = 1'b1;
          fill_d           = fill_q - FillW'(1);
          m_valid_d        = 1'b1;
          m_last_d         = last_entry && (final_q || !g_last_q);
          m_user_d         = last_entry && final_q;
          m_data_d         = {2'b00,
                              (last_entry && final_q) ? total : 9'd0,
                              emit_page_q, emit_y_q, head.x, head.id};
        end
      end
      ST_PLACE: begin
        chain_ctrl.wr_en = 1'b1;
        fill_d           = fill_q + FillW'(1);
        pen_x_d          = sum_x[DimW] ? '1 : sum_x[DimW-1:0];
        tallest_d        = (g_h_q > tallest_q) ? g_h_q : tallest_q;
        state_d          = g_last_q ? ST_LAST : ST_IDLE;
      end
      ST_LAST: begin
        emit_page_d = move ? page_inc : page_q;
        emit_y_d    = top_new_sat;
        page_d      = '0;
        row_top_d   = '0;
        pen_x_d     = '0;
        tallest_d   = '0;
        final_d     = 1'b1;
        state_d     = ST_DRAIN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      page_width_q  <= PageWidthRst;
      page_height_q <= PageHeightRst;
      pen_x_q       <= '0;
      row_top_q     <= '0;
      tallest_q     <= '0;
      page_q        <= '0;
      fill_q        <= '0;
      final_q       <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pen_x_q   <= pen_x_d;
      row_top_q <= row_top_d;
      tallest_q <= tallest_d;
      page_q    <= page_d;
      fill_q    <= fill_d;
      final_q   <= final_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i && (cfg_idx_i == RegPageWidth)) begin
        page_width_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == RegPageHeight)) begin
        page_height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    emit_page_q <= emit_page_d;
    emit_y_q    <= emit_y_d;
    m_data_q    <= m_data_d;
    m_last_q    <= m_last_d;
    m_user_q    <= m_user_d;
    if (in_acc) begin
      g_id_q   <= s_axis_tdata_i[20:0];
      g_w_q    <= s_axis_tdata_i[33:21];
      g_h_q    <= s_axis_tdata_i[46:34];
      g_last_q <= s_axis_tlast_i;
    end
  end

  sap_row_chain #(
    .Depth (ROW_DEPTH),
    .FillW (FillW)
  ) u_row_chain (
    .clk_i      (clk_i),
    .ctrl_i     (chain_ctrl),
    .wr_pos_i   (fill_q),
    .wr_entry_i (wr_entry),
    .head_o     (head)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
